// ===== rtl/core/source_tokenizer_defines.svh =====
// Assertion macros used by the source tokenizer checker.
`ifndef SOURCE_TOKENIZER_DEFINES_SVH
`define SOURCE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge and quiet during reset.
`define STL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising edge and quiet during reset.
`define STL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/stl_pkg.sv =====
// Types, codes and character constants of the source tokenizer.
`default_nettype none

package stl_pkg;

	localparam int POSITION_BITS_DEFAULT = 16;
	localparam int FIFO_DEPTH = 4;

	// Token kinds as they appear on the result word.
	localparam logic [3:0] KIND_SEMI        = 4'd0;
	localparam logic [3:0] KIND_BRACE_OPEN  = 4'd1;
	localparam logic [3:0] KIND_BRACE_CLOSE = 4'd2;
	localparam logic [3:0] KIND_PAREN_OPEN  = 4'd3;
	localparam logic [3:0] KIND_PAREN_CLOSE = 4'd4;
	localparam logic [3:0] KIND_COMMA       = 4'd5;
	localparam logic [3:0] KIND_DOT         = 4'd6;
	localparam logic [3:0] KIND_SET         = 4'd7;
	localparam logic [3:0] KIND_LESS        = 4'd8;
	localparam logic [3:0] KIND_WORD        = 4'd9;
	localparam logic [3:0] KIND_NUMBER      = 4'd10;
	localparam logic [3:0] KIND_STRING      = 4'd11;
	localparam logic [3:0] KIND_ERROR       = 4'd12;
	localparam logic [3:0] KIND_END         = 4'd13;

	// Source characters with a meaning of their own.
	localparam logic [7:0] CH_SPACE       = 8'h20;
	localparam logic [7:0] CH_TAB         = 8'h09;
	localparam logic [7:0] CH_NEWLINE     = 8'h0a;
	localparam logic [7:0] CH_SEMI        = 8'h3b;
	localparam logic [7:0] CH_SLASH       = 8'h2f;
	localparam logic [7:0] CH_LESS        = 8'h3c;
	localparam logic [7:0] CH_DASH        = 8'h2d;
	localparam logic [7:0] CH_BRACE_OPEN  = 8'h7b;
	localparam logic [7:0] CH_BRACE_CLOSE = 8'h7d;
	localparam logic [7:0] CH_PAREN_OPEN  = 8'h28;
	localparam logic [7:0] CH_PAREN_CLOSE = 8'h29;
	localparam logic [7:0] CH_COMMA       = 8'h2c;
	localparam logic [7:0] CH_DOT         = 8'h2e;
	localparam logic [7:0] CH_QUOTE       = 8'h22;

	typedef enum logic [6:0] {
		MODE_IDLE    = 7'b0000001,
		MODE_SLASH   = 7'b0000010,
		MODE_LESS    = 7'b0000100,
		MODE_COMMENT = 7'b0001000,
		MODE_WORD    = 7'b0010000,
		MODE_NUMBER  = 7'b0100000,
		MODE_STRING  = 7'b1000000
	} lex_mode_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_text;
	} char_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  text_byte;
		logic        has_text;
		logic        token_done;
		logic [15:0] line_number;
		logic [15:0] column_number;
	} token_t;

	// Up to two result words produced by one source word.
	typedef struct packed {
		logic [1:0] num;
		token_t     ev0;
		token_t     ev1;
	} evt_pair_t;

endpackage

`default_nettype wire

// ===== rtl/core/stl_lexer.sv =====
// Input register and single-pass lexing logic of the source tokenizer.
`default_nettype none

module stl_lexer #(
	parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	input  stl_pkg::char_t     char_word,
	output logic               char_stall,
	input  logic               room_two,
	output stl_pkg::evt_pair_t evt
);
	import stl_pkg::*;

	typedef logic [POSITION_BITS-1:0] pos_t;

	function automatic pos_t pos_inc(input pos_t v);
		return (v == '1) ? v : pos_t'(v + 1'b1);
	endfunction

	function automatic logic [15:0] pos_out(input pos_t v);
		logic [31:0] w;
		w = 32'(v);
		return w[15:0];
	endfunction

	function automatic token_t mk_tok(input logic [3:0] k, input logic [7:0] t,
			input logic h, input logic d, input pos_t l, input pos_t c);
		token_t r;
		r.kind          = k;
		r.text_byte     = t;
		r.has_text      = h;
		r.token_done    = d;
		r.line_number   = pos_out(l);
		r.column_number = pos_out(c);
		return r;
	endfunction

	logic      valid_s1;
	char_t     word_s1;
	lex_mode_t mode_q;
	pos_t      cur_line_q;
	pos_t      cur_col_q;
	pos_t      start_line_q;
	pos_t      start_col_q;

	logic       fire;
	logic [7:0] b;
	logic       is_letter;
	logic       is_digit;
	logic [3:0] text_kind;

	logic      fr_v;
	token_t    fr_tok;
	lex_mode_t fr_mode;
	logic      fr_mark;

	logic      pre_v;
	token_t    pre_tok;
	logic      sec_v;
	token_t    sec_tok;
	logic      use_fresh;
	lex_mode_t mode_d;
	logic      mark;

	assign fire       = valid_s1 && room_two;
	assign char_stall = valid_s1 && !room_two;

	assign b         = word_s1.char_byte;
	assign is_letter = (b inside {[8'h61:8'h7a], [8'h41:8'h5a]});
	assign is_digit  = (b inside {[8'h30:8'h39]});

	always_comb begin
		case (mode_q)
			MODE_WORD:   text_kind = KIND_WORD;
			MODE_NUMBER: text_kind = KIND_NUMBER;
			default:     text_kind = KIND_STRING;
		endcase
	end

	// A byte lexed from the idle mode at the current position.
	always_comb begin
		fr_v    = 1'b0;
		fr_tok  = mk_tok(KIND_ERROR, b, 1'b0, 1'b1, cur_line_q, cur_col_q);
		fr_mode = MODE_IDLE;
		fr_mark = 1'b0;
		case (b)
			CH_SPACE, CH_TAB, CH_NEWLINE: begin
				fr_v = 1'b0;
			end
			CH_SEMI: begin
				fr_v   = 1'b1;
				fr_tok = mk_tok(KIND_SEMI, 8'h00, 1'b0, 1'b1, cur_line_q, cur_col_q);
			end
			CH_BRACE_OPEN: begin
				fr_v   = 1'b1;
				fr_tok = mk_tok(KIND_BRACE_OPEN, 8'h00, 1'b0, 1'b1, cur_line_q, cur_col_q);
			end
			CH_BRACE_CLOSE: begin
				fr_v   = 1'b1;
				fr_tok = mk_tok(KIND_BRACE_CLOSE, 8'h00, 1'b0, 1'b1, cur_line_q, cur_col_q);
			end
			CH_PAREN_OPEN: begin
				fr_v   = 1'b1;
				fr_tok = mk_tok(KIND_PAREN_OPEN, 8'h00, 1'b0, 1'b1, cur_line_q, cur_col_q);
			end
			CH_PAREN_CLOSE: begin
				fr_v   = 1'b1;
				fr_tok = mk_tok(KIND_PAREN_CLOSE, 8'h00, 1'b0, 1'b1, cur_line_q, cur_col_q);
			end
			CH_COMMA: begin
				fr_v   = 1'b1;
				fr_tok = mk_tok(KIND_COMMA, 8'h00, 1'b0, 1'b1, cur_line_q, cur_col_q);
			end
			CH_DOT: begin
				fr_v   = 1'b1;
				fr_tok = mk_tok(KIND_DOT, 8'h00, 1'b0, 1'b1, cur_line_q, cur_col_q);
			end
			CH_SLASH: begin
				fr_mode = MODE_SLASH;
				fr_mark = 1'b1;
			end
			CH_LESS: begin
				fr_mode = MODE_LESS;
				fr_mark = 1'b1;
			end
			CH_QUOTE: begin
				fr_mode = MODE_STRING;
				fr_mark = 1'b1;
			end
			default: begin
				fr_v = 1'b1;
				if (is_letter) begin
					fr_mark = 1'b1;
					fr_mode = MODE_WORD;
					fr_tok  = mk_tok(KIND_WORD, b, 1'b1, 1'b0, cur_line_q, cur_col_q);
				end else if (is_digit) begin
					fr_mark = 1'b1;
					fr_mode = MODE_NUMBER;
					fr_tok  = mk_tok(KIND_NUMBER, b, 1'b1, 1'b0, cur_line_q, cur_col_q);
				end
			end
		endcase
	end

	// Event of the pending token, then the freshly lexed byte or the end event.
	always_comb begin
		pre_v     = 1'b0;
		pre_tok   = mk_tok(text_kind, 8'h00, 1'b0, 1'b1, start_line_q, start_col_q);
		sec_v     = 1'b0;
		sec_tok   = fr_tok;
		use_fresh = 1'b0;
		mode_d    = mode_q;
		mark      = 1'b0;
		if (word_s1.end_of_text) begin
			case (mode_q)
				MODE_WORD, MODE_NUMBER, MODE_STRING: begin
					pre_v = 1'b1;
				end
				MODE_LESS: begin
					pre_v   = 1'b1;
					pre_tok = mk_tok(KIND_LESS, 8'h00, 1'b0, 1'b1, start_line_q, start_col_q);
				end
				MODE_SLASH: begin
					pre_v   = 1'b1;
					pre_tok = mk_tok(KIND_ERROR, CH_SLASH, 1'b0, 1'b1, start_line_q,
						start_col_q);
				end
				default: begin
					pre_v = 1'b0;
				end
			endcase
			sec_v   = 1'b1;
			sec_tok = mk_tok(KIND_END, 8'h00, 1'b0, 1'b1, cur_line_q, cur_col_q);
			mode_d  = MODE_IDLE;
		end else begin
			case (mode_q)
				MODE_COMMENT: begin
					if (b == CH_NEWLINE) begin
						mode_d = MODE_IDLE;
					end
				end
				MODE_SLASH: begin
					if (b == CH_SLASH) begin
						mode_d = MODE_COMMENT;
					end else begin
						pre_v     = 1'b1;
						pre_tok   = mk_tok(KIND_ERROR, CH_SLASH, 1'b0, 1'b1, start_line_q,
							start_col_q);
						use_fresh = 1'b1;
					end
				end
				MODE_LESS: begin
					pre_v = 1'b1;
					if (b == CH_DASH) begin
						pre_tok = mk_tok(KIND_SET, 8'h00, 1'b0, 1'b1, start_line_q,
							start_col_q);
						mode_d  = MODE_IDLE;
					end else begin
						pre_tok   = mk_tok(KIND_LESS, 8'h00, 1'b0, 1'b1, start_line_q,
							start_col_q);
						use_fresh = 1'b1;
					end
				end
				MODE_WORD, MODE_NUMBER: begin
					pre_v = 1'b1;
					if (is_letter || is_digit) begin
						pre_tok = mk_tok(text_kind, b, 1'b1, 1'b0, start_line_q, start_col_q);
					end else begin
						use_fresh = 1'b1;
					end
				end
				MODE_STRING: begin
					pre_v = 1'b1;
					if (b == CH_QUOTE) begin
						mode_d = MODE_IDLE;
					end else begin
						pre_tok = mk_tok(KIND_STRING, b, 1'b1, 1'b0, start_line_q,
							start_col_q);
					end
				end
				default: begin
					use_fresh = 1'b1;
				end
			endcase
			if (use_fresh) begin
				mode_d  = fr_mode;
				mark    = fr_mark;
				sec_v   = fr_v;
				sec_tok = fr_tok;
			end
		end
	end

	always_comb begin
		evt.ev0 = pre_v ? pre_tok : sec_tok;
		evt.ev1 = sec_tok;
		if (!fire) begin
			evt.num = 2'd0;
		end else begin
			evt.num = 2'(pre_v) + 2'(sec_v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && !char_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			word_s1 <= char_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			cur_line_q   <= pos_t'(1);
			cur_col_q    <= pos_t'(1);
			start_line_q <= pos_t'(1);
			start_col_q  <= pos_t'(1);
		end else if (fire) begin
			if (word_s1.end_of_text) begin
				mode_q       <= MODE_IDLE;
				cur_line_q   <= pos_t'(1);
				cur_col_q    <= pos_t'(1);
				start_line_q <= pos_t'(1);
				start_col_q  <= pos_t'(1);
			end else begin
				mode_q <= mode_d;
				if (mark) begin
					start_line_q <= cur_line_q;
					start_col_q  <= cur_col_q;
				end
				if (b == CH_NEWLINE) begin
					cur_line_q <= pos_inc(cur_line_q);
					cur_col_q  <= pos_t'(1);
				end else begin
					cur_col_q <= pos_inc(cur_col_q);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/stl_token_fifo.sv =====
// Small result queue of the source tokenizer, taking up to two words per cycle.
`default_nettype none

module stl_token_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  stl_pkg::evt_pair_t evt,
	output logic               room_two,
	output logic               token_valid,
	output stl_pkg::token_t    token_word,
	input  logic               token_stall
);
	import stl_pkg::*;

	localparam int PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

	token_t              fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                pop;

	assign token_valid = (count_q != '0);
	assign token_word  = fifo_q[rd_ptr_q];
	assign pop         = token_valid && !token_stall;
	assign room_two    = (count_q <= CNT_BITS'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (evt.num != 2'd0) begin
			fifo_q[wr_ptr_q] <= evt.ev0;
		end
		if (evt.num == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_BITS'(1)] <= evt.ev1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(evt.num);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			count_q <= count_q + CNT_BITS'(evt.num) - CNT_BITS'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/source_tokenizer.sv =====
// Top level of the streaming source tokenizer.
//
// The char channel takes one source word per cycle: a byte and an end-of-text
// flag. Each accepted word gives zero, one or two token words on the token
// channel: punctuators, streamed text bytes of words, numbers and strings,
// token ends, errors, and the end word that closes a run of text.
// An accepted char word sits in the input register, is lexed there in a single
// pass, and its token words are written into the four-entry result queue, where
// the first of them is offered at once if the queue was empty.
// Throughput is one char word per cycle while the queue holds no more than
// two words. While it holds three or more, a char word waiting in the input
// register is held and the char channel stalls, since that word might bring
// two tokens. The queue drains one word a cycle while the receiver does not
// stall, so on gapless text char words that give two tokens can stall the channel.
// When the receiver stalls, words collect in the queue and the char channel
// stalls as soon as the queue is past half full and a char word is waiting.
// Reset clears the queue, the input register, the lexing mode and returns
// line and column to one. An end-of-text word flushes any open token, gives
// the end word and puts the lexer back into its reset state.
`default_nettype none

module source_tokenizer #(
	parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            char_valid,
	input  stl_pkg::char_t  char_word,
	output logic            char_stall,
	output logic            token_valid,
	output stl_pkg::token_t token_word,
	input  logic            token_stall
);
	import stl_pkg::*;

	// Words produced this cycle and whether the queue can take two of them.
	evt_pair_t evt;
	logic      room_two;

	stl_lexer #(
		.POSITION_BITS(POSITION_BITS)
	) u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_word (char_word),
		.char_stall(char_stall),
		.room_two  (room_two),
		.evt       (evt)
	);

	stl_token_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt        (evt),
		.room_two   (room_two),
		.token_valid(token_valid),
		.token_word (token_word),
		.token_stall(token_stall)
	);

endmodule

`default_nettype wire

// ===== rtl/core/stl_checker.sv =====
// Port-level checks of the source tokenizer, bound to its top level.
`default_nettype none

`include "source_tokenizer_defines.svh"

module stl_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            token_valid,
	input stl_pkg::token_t token_word,
	input logic            token_stall
);
	import stl_pkg::*;

	logic tok_wait;
	logic text_seen;
	logic text_ok;
	logic end_seen;
	logic end_ok;
	logic error_seen;
	logic error_ok;

	assign tok_wait   = token_valid && token_stall;
	assign text_seen  = token_valid && token_word.has_text;
	assign text_ok    = !token_word.token_done &&
		(token_word.kind inside {KIND_WORD, KIND_NUMBER, KIND_STRING});
	assign end_seen   = token_valid && (token_word.kind == KIND_END);
	assign end_ok     = token_word.token_done && !token_word.has_text &&
		(token_word.text_byte == 8'h00);
	assign error_seen = token_valid && (token_word.kind == KIND_ERROR);
	assign error_ok   = token_word.token_done && !token_word.has_text;

	`STL_ASSERT_NEXT(a_hold, clk, arst_n, tok_wait, token_valid && $stable(token_word), "word moved")

	`STL_ASSERT_IMPLIES(a_text_kind, clk, arst_n, text_seen, text_ok, "text on wrong kind")

	`STL_ASSERT_IMPLIES(a_end_shape, clk, arst_n, end_seen, end_ok, "malformed end word")

	`STL_ASSERT_IMPLIES(a_error_shape, clk, arst_n, error_seen, error_ok, "malformed error word")

endmodule

bind source_tokenizer stl_checker u_stl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.token_valid(token_valid),
	.token_word (token_word),
	.token_stall(token_stall)
);

`default_nettype wire

// ===== tb/sv/source_tokenizer_test_pkg.sv =====
// Token scoreboard for the source tokenizer bench: it predicts and checks the token words.
package source_tokenizer_test_pkg;

	import stl_pkg::*;

	localparam logic [15:0] POSITION_MAX = 16'hffff;

	class token_scoreboard;

		token_t expected_tokens[$];
		lex_mode_t mode;
		logic [15:0] line_no;
		logic [15:0] column_no;
		logic [15:0] token_line;
		logic [15:0] token_column;
		int mismatches;
		int tokens_checked;
		int chars_noted;

		function new();
			mismatches = 0;
			tokens_checked = 0;
			chars_noted = 0;
			restart();
		endfunction

		function void restart();
			mode = MODE_IDLE;
			line_no = 16'd1;
			column_no = 16'd1;
			token_line = 16'd1;
			token_column = 16'd1;
		endfunction

		function bit is_letter(logic [7:0] b);
			return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
		endfunction

		function bit is_digit(logic [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		function logic [15:0] step_position(logic [15:0] v);
			return (v == POSITION_MAX) ? v : v + 16'd1;
		endfunction

		function logic [3:0] text_kind();
			if (mode == MODE_WORD)
				return KIND_WORD;
			if (mode == MODE_NUMBER)
				return KIND_NUMBER;
			return KIND_STRING;
		endfunction

		function void queue_token(logic [3:0] kind, logic [7:0] text, logic has, logic done,
				logic [15:0] ln, logic [15:0] cn);
			token_t t;
			t.kind = kind;
			t.text_byte = text;
			t.has_text = has;
			t.token_done = done;
			t.line_number = ln;
			t.column_number = cn;
			expected_tokens.insert(expected_tokens.size(), t);
		endfunction

		function void mark_start();
			token_line = line_no;
			token_column = column_no;
		endfunction

		// Lexes a byte from the idle mode at the current position.
		function void open_token(logic [7:0] b);
			case (b)
				CH_SPACE, CH_TAB, CH_NEWLINE: ;
				CH_SEMI:        queue_token(KIND_SEMI, 8'h00, 1'b0, 1'b1, line_no, column_no);
				CH_BRACE_OPEN:  queue_token(KIND_BRACE_OPEN, 8'h00, 1'b0, 1'b1, line_no, column_no);
				CH_BRACE_CLOSE: queue_token(KIND_BRACE_CLOSE, 8'h00, 1'b0, 1'b1, line_no, column_no);
				CH_PAREN_OPEN:  queue_token(KIND_PAREN_OPEN, 8'h00, 1'b0, 1'b1, line_no, column_no);
				CH_PAREN_CLOSE: queue_token(KIND_PAREN_CLOSE, 8'h00, 1'b0, 1'b1, line_no, column_no);
				CH_COMMA:       queue_token(KIND_COMMA, 8'h00, 1'b0, 1'b1, line_no, column_no);
				CH_DOT:         queue_token(KIND_DOT, 8'h00, 1'b0, 1'b1, line_no, column_no);
				CH_SLASH: begin
					mark_start();
					mode = MODE_SLASH;
				end
				CH_LESS: begin
					mark_start();
					mode = MODE_LESS;
				end
				CH_QUOTE: begin
					mark_start();
					mode = MODE_STRING;
				end
				default: begin
					if (is_letter(b) || is_digit(b)) begin
						mark_start();
						mode = is_letter(b) ? MODE_WORD : MODE_NUMBER;
						queue_token(text_kind(), b, 1'b1, 1'b0, token_line, token_column);
					end else begin
						queue_token(KIND_ERROR, b, 1'b0, 1'b1, line_no, column_no);
					end
				end
			endcase
		endfunction

		// Works out the token words that one accepted char word gives.
		function void note_char(char_t c);
			logic [7:0] b;
			logic [3:0] open_kind;
			b = c.char_byte;
			open_kind = text_kind();
			chars_noted++;
			if (c.end_of_text) begin
				case (mode)
					MODE_WORD, MODE_NUMBER, MODE_STRING:
						queue_token(open_kind, 8'h00, 1'b0, 1'b1, token_line, token_column);
					MODE_LESS:
						queue_token(KIND_LESS, 8'h00, 1'b0, 1'b1, token_line, token_column);
					MODE_SLASH:
						queue_token(KIND_ERROR, CH_SLASH, 1'b0, 1'b1, token_line, token_column);
					default: ;
				endcase
				queue_token(KIND_END, 8'h00, 1'b0, 1'b1, line_no, column_no);
				restart();
				return;
			end
			case (mode)
				MODE_COMMENT: begin
					if (b == CH_NEWLINE)
						mode = MODE_IDLE;
				end
				MODE_SLASH: begin
					if (b == CH_SLASH) begin
						mode = MODE_COMMENT;
					end else begin
						queue_token(KIND_ERROR, CH_SLASH, 1'b0, 1'b1, token_line, token_column);
						mode = MODE_IDLE;
						open_token(b);
					end
				end
				MODE_LESS: begin
					mode = MODE_IDLE;
					if (b == CH_DASH) begin
						queue_token(KIND_SET, 8'h00, 1'b0, 1'b1, token_line, token_column);
					end else begin
						queue_token(KIND_LESS, 8'h00, 1'b0, 1'b1, token_line, token_column);
						open_token(b);
					end
				end
				MODE_WORD, MODE_NUMBER: begin
					if (is_letter(b) || is_digit(b)) begin
						queue_token(open_kind, b, 1'b1, 1'b0, token_line, token_column);
					end else begin
						queue_token(open_kind, 8'h00, 1'b0, 1'b1, token_line, token_column);
						mode = MODE_IDLE;
						open_token(b);
					end
				end
				MODE_STRING: begin
					if (b == CH_QUOTE) begin
						queue_token(KIND_STRING, 8'h00, 1'b0, 1'b1, token_line, token_column);
						mode = MODE_IDLE;
					end else begin
						queue_token(KIND_STRING, b, 1'b1, 1'b0, token_line, token_column);
					end
				end
				default: begin
					mode = MODE_IDLE;
					open_token(b);
				end
			endcase
			if (b == CH_NEWLINE) begin
				line_no = step_position(line_no);
				column_no = 16'd1;
			end else begin
				column_no = step_position(column_no);
			end
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("mismatch: %s", what);
		endtask

		task compare_field(string field, logic [15:0] got_value, logic [15:0] want_value);
			if (got_value !== want_value)
				report_mismatch($sformatf("token word %0d: %s is %0h, expected %0h",
					tokens_checked, field, got_value, want_value));
		endtask

		task check_token(token_t got);
			token_t want;
			tokens_checked++;
			if (expected_tokens.size() == 0) begin
				report_mismatch($sformatf("token word %0d of kind %0d arrived with none expected",
					tokens_checked, got.kind));
				return;
			end
			want = expected_tokens.pop_front();
			compare_field("kind", 16'(got.kind), 16'(want.kind));
			compare_field("text_byte", 16'(got.text_byte), 16'(want.text_byte));
			compare_field("has_text", 16'(got.has_text), 16'(want.has_text));
			compare_field("token_done", 16'(got.token_done), 16'(want.token_done));
			compare_field("line_number", got.line_number, want.line_number);
			compare_field("column_number", got.column_number, want.column_number);
		endtask

		task finish_check();
			if (expected_tokens.size() != 0)
				report_mismatch($sformatf("%0d token words never arrived", expected_tokens.size()));
		endtask

	endclass

endpackage

// ===== tb/sv/source_tokenizer_test.sv =====
// Top-level regression bench for the source tokenizer, with its drivers and checks.
module source_tokenizer_test;

	import stl_pkg::*;
	import source_tokenizer_test_pkg::*;

	// The run is far shorter than this; the limit only catches a hung handshake.
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_WORDS_PER_PHASE = 375;
	// Quiet time after the last expected token word, with some margin.
	localparam int SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic char_valid = 1'b0;
	char_t char_word = '0;
	logic char_stall;
	logic token_valid;
	token_t token_word;
	logic token_stall = 1'b0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycle_count = 0;
	int text_runs = 0;
	int phase_start = 0;
	token_scoreboard token_board = new();

	source_tokenizer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_word   (char_word),
		.char_stall  (char_stall),
		.token_valid (token_valid),
		.token_word  (token_word),
		.token_stall (token_stall)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog: a run that has not finished by the limit is a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("source_tokenizer regression: fail");
			$finish;
		end
	end

	// The receiver stalls at random, at the rate of the current phase. The stall
	// changes only on the falling edge, so it is steady when the rising edge samples it.
	always @(negedge clk) begin
		token_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Every token word taken at a rising edge goes to the scoreboard, which compares it
	// with the oldest word still expected.
	always @(posedge clk) begin
		if (arst_n && token_valid && !token_stall)
			token_board.check_token(token_word);
	end

	// Offers one char word. A random number of idle cycles may come first; once valid
	// is raised, the word is held until a rising edge sees no stall, and that edge is
	// where the scoreboard learns of it. Valid is left high, so the next call either
	// lowers it for an idle cycle or puts the next word straight on the channel.
	task automatic send_char(input logic [7:0] b, input logic eot);
		char_t c;
		c.char_byte = b;
		c.end_of_text = eot;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		char_word <= c;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		token_board.note_char(c);
		if (eot)
			text_runs++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	function automatic logic [7:0] random_letter();
		return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] random_alnum();
		if ($urandom_range(3) == 0)
			return 8'h30 + 8'($urandom_range(9));
		return random_letter();
	endfunction

	// One fragment of plausible source text. Most fragments are well formed, so the
	// lexer spends its time in words, strings and comments; a share are lone slashes,
	// lone less-than signs, unclosed strings and comments, and raw noise bytes.
	task automatic send_fragment();
		logic [7:0] b;
		int pick;
		pick = $urandom_range(99);
		if (pick < 20) begin
			send_char(random_letter(), 1'b0);
			repeat ($urandom_range(6))
				send_char(random_alnum(), 1'b0);
		end else if (pick < 32) begin
			send_char(8'h30 + 8'($urandom_range(9)), 1'b0);
			repeat ($urandom_range(4))
				send_char(random_alnum(), 1'b0);
		end else if (pick < 42) begin
			// String body bytes take any value but the quote; a newline stands in for it.
			send_char(CH_QUOTE, 1'b0);
			repeat ($urandom_range(6)) begin
				b = 8'($urandom_range(255));
				send_char((b == CH_QUOTE) ? CH_NEWLINE : b, 1'b0);
			end
			if ($urandom_range(9) != 0)
				send_char(CH_QUOTE, 1'b0);
		end else if (pick < 60) begin
			case ($urandom_range(6))
				0: send_char(CH_SEMI, 1'b0);
				1: send_char(CH_BRACE_OPEN, 1'b0);
				2: send_char(CH_BRACE_CLOSE, 1'b0);
				3: send_char(CH_PAREN_OPEN, 1'b0);
				4: send_char(CH_PAREN_CLOSE, 1'b0);
				5: send_char(CH_COMMA, 1'b0);
				default: send_char(CH_DOT, 1'b0);
			endcase
		end else if (pick < 66) begin
			send_char(CH_LESS, 1'b0);
			send_char(CH_DASH, 1'b0);
		end else if (pick < 70) begin
			send_char(CH_LESS, 1'b0);
		end else if (pick < 76) begin
			// Comment bodies avoid the newline, which is kept for the end of the comment.
			send_char(CH_SLASH, 1'b0);
			send_char(CH_SLASH, 1'b0);
			repeat ($urandom_range(5)) begin
				b = 8'($urandom_range(255));
				send_char((b == CH_NEWLINE) ? CH_SPACE : b, 1'b0);
			end
			if ($urandom_range(9) != 0)
				send_char(CH_NEWLINE, 1'b0);
		end else if (pick < 90) begin
			case ($urandom_range(2))
				0: send_char(CH_SPACE, 1'b0);
				1: send_char(CH_TAB, 1'b0);
				default: send_char(CH_NEWLINE, 1'b0);
			endcase
		end else if (pick < 95) begin
			send_char(CH_SLASH, 1'b0);
		end else begin
			send_char(8'($urandom_range(255)), 1'b0);
		end
	endtask

	// A run of text of about the given length, closed by an end-of-text word whose
	// byte is random, since the block must ignore it.
	task automatic send_text_run(input int length);
		int start;
		start = token_board.chars_noted;
		while (token_board.chars_noted - start < length)
			send_fragment();
		send_char(8'($urandom_range(255)), 1'b1);
	endtask

	// Lowers valid and waits until every expected token word has come out.
	task automatic drain();
		@(negedge clk);
		char_valid <= 1'b0;
		while (token_board.expected_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	initial begin
		repeat (RESET_CYCLES)
			@(negedge clk);
		arst_n <= 1'b1;

		// Directed text: every punctuator, an assignment, a lone less-than before a
		// number, a lone slash before a word, a line comment, an empty string, a string
		// holding a zero byte, a newline and a high byte, then zero and high bytes
		// outside any string, and a word left open at the end of text.
		send_text(";{}(),.\t<-<1/x//c\n\"\"\"");
		send_char(8'h00, 1'b0);
		send_char(CH_NEWLINE, 1'b0);
		send_char(8'hff, 1'b0);
		send_char(CH_QUOTE, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'hff, 1'b0);
		send_text("a");
		send_char(8'h00, 1'b1);
		drain();

		// Random text runs under four idling mixes: none, the sender idle more than half
		// the time, the receiver stalling more than half the time, and both lightly.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 52;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 52;
				end
				default: begin
					send_idle_pct = 12;
					recv_stall_pct = 12;
				end
			endcase
			phase_start = token_board.chars_noted;
			while (token_board.chars_noted - phase_start < RANDOM_WORDS_PER_PHASE)
				send_text_run($urandom_range(4, 60));
			drain();
		end

		token_board.finish_check();
		$display("Covered %0d char words over %0d text runs; %0d token words were checked.",
			token_board.chars_noted, text_runs, token_board.tokens_checked);
		$display("Directed punctuator, comment, string and error text ran first, then random text under four idling mixes.");
		if (token_board.mismatches == 0) begin
			$display("source_tokenizer regression: pass");
		end else begin
			$display("%0d mismatches", token_board.mismatches);
			$display("source_tokenizer regression: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/stl_pkg.sv
rtl/core/stl_lexer.sv
rtl/core/stl_token_fifo.sv
rtl/core/source_tokenizer.sv
rtl/core/stl_checker.sv
tb/sv/source_tokenizer_test_pkg.sv
tb/sv/source_tokenizer_test.sv
